@@ sv/mmf_pkg.sv @@
package mmf_pkg;

   // result field widths fixed by the interface
   localparam int RES_W = 35;
   localparam int POS_W = 3;
   localparam int DIM_REG_W = 4;
   localparam int CSR_IDX_W = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_A_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_A_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B_ROWS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_B_COLS = 2'd3;

   // sequencer states
   typedef enum logic [2:0] {
      ST_LOAD  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } mmf_state_type;

   // control that travels with each multiply-accumulate through the pipe
   typedef struct packed {
      logic             first;  // first term of a dot product
      logic             last;   // last term, result leaves after it
      logic             final_; // last result of the product
      logic             err;    // dimension error result
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } mmf_tag_type;

endpackage

@@ sv/matrix_multiply_fixed.sv @@
// fixed-point matrix multiplier, C = A * B
// config: csr_valid/csr_ready with csr_index selecting a_rows, a_cols, b_rows,
//   b_cols (4 bits each, 0 taken as 1, above MAX_DIM taken as MAX_DIM);
//   csr_ready is always high, write only while busy is low
// input: a transaction is taken on start with busy low; req_element_value
//   carries the elements of A then of B, row-major, signed Q8.8,
//   one per cycle while loading
// output: after the last B element busy rises and the product C leaves in
//   row-major order, one result per rsp_valid strobe, signed Q19.16 with row
//   and column; rsp_last_result marks the final one. if B is 1x1 the result
//   is A times that scalar; if inner dimensions differ a single result with
//   rsp_dim_error set and value zero is given
// compute: the single MAC unit takes one inner term per cycle, a_cols terms
//   per C element (one for scalar B and for the error result); each term
//   passes the element memory read register and the MAC product and
//   accumulate stages before its result, and busy falls in the cycle after
//   the final result
// the receiver cannot stall; results are strobed once
// reset clears the load counter, sequencer state and registers (to 1); element
//   memories are not cleared and must be loaded before use
module matrix_multiply_fixed #(
   parameter int MAX_DIM    = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // element input
   input  logic                                start,
   output logic                                busy,
   input  logic signed [ELEM_WIDTH-1:0]        req_element_value,
   // results
   output logic                                rsp_valid,
   output logic signed [mmf_pkg::RES_W-1:0]    rsp_product_value,
   output logic [mmf_pkg::POS_W-1:0]           rsp_out_row,
   output logic [mmf_pkg::POS_W-1:0]           rsp_out_col,
   output logic                                rsp_dim_error,
   output logic                                rsp_last_result,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mmf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mmf_pkg::DIM_REG_W-1:0]       csr_wdata
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int LOAD_W = $clog2(DEPTH + 1);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int IDX_W  = $clog2(MAX_DIM);

   // dimension registers
   logic [mmf_pkg::DIM_REG_W-1:0] a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;

   // loading state
   logic              accept;
   logic [LOAD_W-1:0] load_count_ff, load_count_in, need;
   logic              loading_b_ff;
   logic              phase_done;
   logic              b_done;

   // sequencer
   mmf_pkg::mmf_state_type state_ff, state_in;
   logic [DIM_W-1:0] ar_ff, ac_ff, bc_ff, nk_ff, nj_ff;
   logic             scalar_ff, err_ff;
   logic [IDX_W-1:0] i_ff, j_ff, k_ff;
   logic             k_end, j_end, i_end, issue_valid, issue_done;
   mmf_pkg::mmf_tag_type issue_tag;
   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;

   // clamped dimensions from the current registers
   logic [DIM_W-1:0] cl_ar, cl_ac, cl_br, cl_bc;

   // memory and mac
   logic signed [ELEM_WIDTH-1:0] rd_data_a, rd_data_b;
   logic                         res_valid;
   logic [mmf_pkg::RES_W-1:0]    res_value;
   mmf_pkg::mmf_tag_type         res_tag;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [mmf_pkg::DIM_REG_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) begin
         r = DIM_W'(1);
      end else if (d > mmf_pkg::DIM_REG_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(d);
      end
      return r;
   endfunction

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= mmf_pkg::DIM_REG_W'(1);
         a_cols_ff <= mmf_pkg::DIM_REG_W'(1);
         b_rows_ff <= mmf_pkg::DIM_REG_W'(1);
         b_cols_ff <= mmf_pkg::DIM_REG_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mmf_pkg::CSR_A_ROWS: a_rows_ff <= csr_wdata;
            mmf_pkg::CSR_A_COLS: a_cols_ff <= csr_wdata;
            mmf_pkg::CSR_B_ROWS: b_rows_ff <= csr_wdata;
            mmf_pkg::CSR_B_COLS: b_cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cl_ar = clamp_dim(a_rows_ff);
   assign cl_ac = clamp_dim(a_cols_ff);
   assign cl_br = clamp_dim(b_rows_ff);
   assign cl_bc = clamp_dim(b_cols_ff);

   // ---------------- loading ----------------
   assign busy     = (state_ff != mmf_pkg::ST_LOAD);
   assign accept   = start && !busy;

   // element count of the phase in progress, from the registers now in force
   assign need = loading_b_ff ? LOAD_W'(cl_br) * LOAD_W'(cl_bc)
                              : LOAD_W'(cl_ar) * LOAD_W'(cl_ac);
   assign load_count_in = load_count_ff + LOAD_W'(1);
   assign phase_done    = (load_count_in >= need);
   assign b_done        = accept && loading_b_ff && phase_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         loading_b_ff  <= 1'b0;
      end else if (accept) begin
         if (phase_done) begin
            load_count_ff <= '0;
            loading_b_ff  <= !loading_b_ff;
         end else begin
            load_count_ff <= load_count_in;
         end
      end
   end

   // ---------------- compute sequencer ----------------
   // inner index k runs fastest, then column j, then row i
   assign k_end = (k_ff == IDX_W'(nk_ff - DIM_W'(1)));
   assign j_end = (j_ff == IDX_W'(nj_ff - DIM_W'(1)));
   assign i_end = (i_ff == IDX_W'(ar_ff - DIM_W'(1)));
   assign issue_valid = (state_ff == mmf_pkg::ST_ISSUE);
   assign issue_done  = err_ff || (k_end && j_end && i_end);

   always_comb begin
      issue_tag.first  = (k_ff == '0) || err_ff;
      issue_tag.last   = k_end || err_ff;
      issue_tag.final_ = (k_end && j_end && i_end) || err_ff;
      issue_tag.err    = err_ff;
      issue_tag.row    = err_ff ? '0 : mmf_pkg::POS_W'(i_ff);
      issue_tag.col    = err_ff ? '0 : mmf_pkg::POS_W'(j_ff);
   end

   // scalar case walks A with b at entry zero; otherwise row of A times column of B
   assign rd_addr_a = ADDR_W'(i_ff) * ADDR_W'(ac_ff)
                    + (scalar_ff ? ADDR_W'(j_ff) : ADDR_W'(k_ff));
   assign rd_addr_b = scalar_ff ? '0 : ADDR_W'(k_ff) * ADDR_W'(bc_ff) + ADDR_W'(j_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mmf_pkg::ST_LOAD: begin
            if (b_done) state_in = mmf_pkg::ST_ISSUE;
         end
         mmf_pkg::ST_ISSUE: begin
            if (issue_done) state_in = mmf_pkg::ST_DRAIN;
         end
         mmf_pkg::ST_DRAIN: begin
            if (res_valid && res_tag.final_) state_in = mmf_pkg::ST_LOAD;
         end
         default: state_in = mmf_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mmf_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // latch dimensions at the last B element; the memory write of that element
   // lands before the first read, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (b_done) begin
         ar_ff     <= cl_ar;
         ac_ff     <= cl_ac;
         bc_ff     <= cl_bc;
         scalar_ff <= (cl_br == DIM_W'(1)) && (cl_bc == DIM_W'(1));
         err_ff    <= !((cl_br == DIM_W'(1)) && (cl_bc == DIM_W'(1))) && (cl_ac != cl_br);
         if ((cl_br == DIM_W'(1)) && (cl_bc == DIM_W'(1))) begin
            nk_ff <= DIM_W'(1);
            nj_ff <= cl_ac;
         end else begin
            nk_ff <= cl_ac;
            nj_ff <= cl_bc;
         end
         i_ff <= '0;
         j_ff <= '0;
         k_ff <= '0;
      end else if (issue_valid && !issue_done) begin
         if (k_end) begin
            k_ff <= '0;
            if (j_end) begin
               j_ff <= '0;
               i_ff <= i_ff + IDX_W'(1);
            end else begin
               j_ff <= j_ff + IDX_W'(1);
            end
         end else begin
            k_ff <= k_ff + IDX_W'(1);
         end
      end
   end

   // ---------------- datapath ----------------
   mmf_store #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_store (
      .clock     (clock),
      .wr_a      (accept && !loading_b_ff),
      .wr_b      (accept && loading_b_ff),
      .wr_addr   (load_count_ff[ADDR_W-1:0]),
      .wr_data   (req_element_value),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   mmf_mac #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_mac (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (issue_valid),
      .issue_tag   (issue_tag),
      .rd_data_a   (rd_data_a),
      .rd_data_b   (rd_data_b),
      .res_valid   (res_valid),
      .res_value   (res_value),
      .res_tag     (res_tag)
   );

   // result transaction straight from the mac output registers
   assign rsp_valid         = res_valid;
   assign rsp_product_value = res_value;
   assign rsp_out_row       = res_tag.row;
   assign rsp_out_col       = res_tag.col;
   assign rsp_dim_error     = res_tag.err;
   assign rsp_last_result   = res_tag.final_;

   // ---------------- checks ----------------
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside compute");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_result) |=> !busy)
      else $error("block still busy after final result");

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dim_error) |-> (rsp_last_result && rsp_product_value == '0))
      else $error("error result malformed");

   a_no_issue_in_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mmf_pkg::ST_LOAD) |=> !rsp_valid || $past(busy, 1) || busy)
      else $error("result without compute");

endmodule

@@ sv/mmf_store.sv @@
module mmf_store #(
   parameter int MAX_DIM    = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         wr_a,
   input  logic                         wr_b,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr,
   input  logic signed [ELEM_WIDTH-1:0] wr_data,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_addr_a,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_addr_b,
   output logic signed [ELEM_WIDTH-1:0] rd_data_a,
   output logic signed [ELEM_WIDTH-1:0] rd_data_b
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;

   logic signed [ELEM_WIDTH-1:0] a_mem [DEPTH];
   logic signed [ELEM_WIDTH-1:0] b_mem [DEPTH];
   logic signed [ELEM_WIDTH-1:0] rd_a_ff;
   logic signed [ELEM_WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_a) begin
         a_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= a_mem[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         b_mem[wr_addr] <= wr_data;
      end
      rd_b_ff <= b_mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ sv/mmf_mac.sv @@
module mmf_mac #(
   parameter int ELEM_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         issue_valid,
   input  mmf_pkg::mmf_tag_type         issue_tag,
   input  logic signed [ELEM_WIDTH-1:0] rd_data_a,
   input  logic signed [ELEM_WIDTH-1:0] rd_data_b,
   output logic                         res_valid,
   output logic [mmf_pkg::RES_W-1:0]    res_value,
   output mmf_pkg::mmf_tag_type         res_tag
);

   localparam int PROD_W = 2 * ELEM_WIDTH;
   localparam int EXT_W  = (PROD_W > mmf_pkg::RES_W) ? PROD_W : mmf_pkg::RES_W;

   // stage 1: memory data comes back
   logic                 v1_ff;
   mmf_pkg::mmf_tag_type t1_ff;
   // stage 2: product
   logic                 v2_ff;
   mmf_pkg::mmf_tag_type t2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [EXT_W-1:0]  prod_ext;
   // stage 3: accumulate and result
   logic [mmf_pkg::RES_W-1:0] acc_ff;
   logic [mmf_pkg::RES_W-1:0] acc_in;
   logic                      res_valid_ff;
   logic [mmf_pkg::RES_W-1:0] res_value_ff;
   mmf_pkg::mmf_tag_type      res_tag_ff;

   assign prod_in  = rd_data_a * rd_data_b;
   assign prod_ext = EXT_W'(prod_ff);
   // sum wraps at the result width
   assign acc_in   = t2_ff.first ? prod_ext[mmf_pkg::RES_W-1:0]
                                 : acc_ff + prod_ext[mmf_pkg::RES_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= issue_valid;
         v2_ff        <= v1_ff;
         res_valid_ff <= v2_ff && t2_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      t1_ff   <= issue_tag;
      t2_ff   <= t1_ff;
      prod_ff <= prod_in;
      if (v2_ff) begin
         acc_ff <= acc_in;
      end
      if (v2_ff && t2_ff.last) begin
         res_value_ff <= t2_ff.err ? '0 : acc_in;
         res_tag_ff   <= t2_ff;
      end
   end

   assign res_valid = res_valid_ff;
   assign res_value = res_value_ff;
   assign res_tag   = res_tag_ff;

endmodule
